// ===== src/point_polyline_min_distance_assert.svh =====
// Assertion macros for the point to polyline distance block.
// Used by the top level only; no other dependencies.
`ifndef POINT_POLYLINE_MIN_DISTANCE_ASSERT_SVH
`define POINT_POLYLINE_MIN_DISTANCE_ASSERT_SVH
`ifndef SYNTH
`define PPMD_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`define PPMD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication failed");
`define PPMD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");
`else
`define PPMD_ASSERT_NEVER(lbl, cond)
`define PPMD_ASSERT_IMP(lbl, ante, cons)
`define PPMD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== src/ppmd_pkg.sv =====
// Shared constants for the point to polyline distance block.
// No dependencies.
package ppmd_pkg;

  localparam int DIST_FRAC_BITS = 8;
  localparam int T_FRAC         = 30;
  localparam int DIST_SHIFT     = 32 - DIST_FRAC_BITS;
  localparam int MUL_W          = 64;
  localparam int PROD_W         = 2 * MUL_W;
  localparam int CNT_W          = $clog2(MUL_W + 1);
  localparam int REM_W          = 100;
  localparam int QCNT_W         = $clog2(T_FRAC + 1);
  localparam int OFF_W          = 66;

  localparam logic [31:0] LON_SCALE_RST = 32'd29709148;
  localparam logic [31:0] LAT_SCALE_RST = 32'd47811575;
  localparam logic [31:0] RADIUS_RST    = 32'd2500;

  localparam logic [1:0] REG_LON_SCALE = 2'd0;
  localparam logic [1:0] REG_LAT_SCALE = 2'd1;
  localparam logic [1:0] REG_RADIUS    = 2'd2;

endpackage

// ===== src/point_polyline_min_distance.sv =====
// Top level: sequencer, configuration registers and running minimum.
// Depends on ppmd_pkg, ppmd_mul, ppmd_div and the assertion header.
//
// One segment request at a time. Every scaling, square and product runs
// through one shared bit-serial multiplier; the projection parameter comes
// from a bit-serial divider. A segment of nonzero length takes 14 multiplies
// plus the divide when the projection falls strictly inside the segment; a
// zero-length segment takes 8 multiplies. Results leave through an output
// register, so the next request is taken while a result waits, unless a
// second result is ready before the first was taken.
module point_polyline_min_distance (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [31:0]  point_lon,
  input  logic [30:0]  point_lat,
  input  logic [31:0]  start_lon,
  input  logic [30:0]  start_lat,
  input  logic [31:0]  end_lon,
  input  logic [30:0]  end_lat,
  input  logic         last_segment,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [63:0]  best_sq,
  output logic         within_radius,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import ppmd_pkg::*;

  `include "point_polyline_min_distance_assert.svh"

  typedef enum logic [2:0] {
    S_IDLE, S_MUL_GO, S_MUL_WAIT, S_DIV_GO, S_DIV_WAIT, S_FIN
  } state_t;

  typedef enum logic [3:0] {
    OP_DXM, OP_DYM, OP_DX2, OP_DY2, OP_AX, OP_AY, OP_P1, OP_P2,
    OP_OFFX, OP_OFFY, OP_MX, OP_MY, OP_MX2, OP_MY2
  } op_t;

  state_t state;
  op_t    op;

  logic [31:0] lon_factor, lat_factor, radius;
  logic [63:0] running_min;

  logic signed [31:0] x1, px;
  logic signed [30:0] y1, py;
  logic signed [63:0] exs, eys, dax, day;
  logic               last;

  logic [MUL_W-1:0]  dxm, dym, axm, aym, fxm, fym, mx, mym;
  logic [REM_W-1:0]  den, p1, num, den_sum, p2w;
  logic              neg, ax_neg, ay_neg, n1, n2, need_div;
  logic [T_FRAC:0]   t;
  logic [OFF_W-1:0]  offx;
  logic [PROD_W-1:0] sq, sq_sum;
  logic [63:0]       seg_sq, seg_sq_next, newmin;
  logic signed [63:0] nx, ny;

  logic              mul_start, mul_busy, mul_done;
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod;
  logic              div_start, div_busy, div_done;
  logic [T_FRAC-1:0] quo;
  logic              out_load;

  function automatic logic [63:0] mag(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  // start + t*e truncated toward zero
  function automatic logic signed [63:0] along(input logic signed [31:0] a,
                                               input logic signed [63:0] e,
                                               input logic [OFF_W-1:0] off);
    logic signed [67:0] v;
    logic signed [67:0] o;
    o = $signed({2'b00, off});
    v = (68'(a) <<< T_FRAC) + (e[63] ? -o : o);
    return v[67] ? 64'(-((-v) >>> T_FRAC)) : 64'(v >>> T_FRAC);
  endfunction

  assign dax = 64'(px) - 64'(x1);
  assign day = 64'(py) - 64'(y1);

  always_comb begin
    unique case (op)
      OP_DXM:  begin mul_a = mag(exs); mul_b = 64'(lon_factor); end
      OP_DYM:  begin mul_a = mag(eys); mul_b = 64'(lat_factor); end
      OP_DX2:  begin mul_a = dxm;      mul_b = dxm;             end
      OP_DY2:  begin mul_a = dym;      mul_b = dym;             end
      OP_AX:   begin mul_a = mag(dax); mul_b = 64'(lon_factor); end
      OP_AY:   begin mul_a = mag(day); mul_b = 64'(lat_factor); end
      OP_P1:   begin mul_a = axm;      mul_b = dxm;             end
      OP_P2:   begin mul_a = aym;      mul_b = dym;             end
      OP_OFFX: begin mul_a = mag(exs); mul_b = 64'(t);          end
      OP_OFFY: begin mul_a = mag(eys); mul_b = 64'(t);          end
      OP_MX:   begin mul_a = fxm;      mul_b = 64'(lon_factor); end
      OP_MY:   begin mul_a = fym;      mul_b = 64'(lat_factor); end
      OP_MX2:  begin mul_a = mx;       mul_b = mx;              end
      OP_MY2:  begin mul_a = mym;      mul_b = mym;             end
      default: begin mul_a = '0;       mul_b = '0;              end
    endcase
  end

  // signed dot product from the two magnitude products
  always_comb begin
    p2w    = prod[REM_W-1:0];
    ax_neg = dax[63] && (axm != '0);
    ay_neg = day[63] && (aym != '0);
    n1     = ax_neg ^ exs[63];
    n2     = ay_neg ^ eys[63];
    if (n1 == n2) begin
      num = p1 + p2w;
      neg = n1;
    end else if (p1 >= p2w) begin
      num = p1 - p2w;
      neg = n1;
    end else begin
      num = p2w - p1;
      neg = n2;
    end
    need_div = !neg && (num != '0) && (num < den);
    den_sum = den + prod[REM_W-1:0];
    nx      = along(x1, exs, offx);
    ny      = along(32'(y1), eys, prod[OFF_W-1:0]);
    sq_sum  = sq + prod;
    seg_sq_next = (sq_sum[PROD_W-1:64+DIST_SHIFT] != '0) ? '1
                : sq_sum[DIST_SHIFT+63:DIST_SHIFT];
    newmin  = (seg_sq < running_min) ? seg_sq : running_min;
  end

  assign mul_start = (state == S_MUL_GO);
  assign div_start = (state == S_DIV_GO);
  assign in_ready  = (state == S_IDLE);
  assign out_load  = (state == S_FIN) && last && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      op          <= OP_DXM;
      out_valid   <= 1'b0;
      running_min <= '1;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            px    <= $signed(point_lon);
            py    <= $signed(point_lat);
            x1    <= $signed(start_lon);
            y1    <= $signed(start_lat);
            exs   <= 64'($signed(end_lon)) - 64'($signed(start_lon));
            eys   <= 64'($signed(end_lat)) - 64'($signed(start_lat));
            last  <= last_segment;
            op    <= OP_DXM;
            state <= S_MUL_GO;
          end
        end
        S_MUL_GO: state <= S_MUL_WAIT;
        S_MUL_WAIT: begin
          if (mul_done) begin
            if (op == OP_MY2) begin
              state <= S_FIN;
            end else if (op == OP_P2 && need_div) begin
              state <= S_DIV_GO;
            end else begin
              state <= S_MUL_GO;
            end
            unique case (op)
              OP_DXM: begin dxm <= prod[79:16]; op <= OP_DYM; end
              OP_DYM: begin dym <= prod[79:16]; op <= OP_DX2; end
              OP_DX2: begin den <= prod[REM_W-1:0]; op <= OP_DY2; end
              OP_DY2: begin
                den <= den_sum;
                if (den_sum == '0) begin
                  // zero length: distance to the start vertex
                  fxm <= mag(dax);
                  fym <= mag(day);
                  op  <= OP_MX;
                end else begin
                  op <= OP_AX;
                end
              end
              OP_AX: begin axm <= prod[79:16]; op <= OP_AY; end
              OP_AY: begin aym <= prod[79:16]; op <= OP_P1; end
              OP_P1: begin p1 <= prod[REM_W-1:0]; op <= OP_P2; end
              OP_P2: begin
                op <= OP_OFFX;
                if (neg || num == '0) begin
                  t <= '0;
                end else if (num >= den) begin
                  t <= (T_FRAC+1)'(1) << T_FRAC;
                end
              end
              OP_OFFX: begin offx <= prod[OFF_W-1:0]; op <= OP_OFFY; end
              OP_OFFY: begin
                fxm <= mag(nx - 64'(px));
                fym <= mag(ny - 64'(py));
                op  <= OP_MX;
              end
              OP_MX:  begin mx <= prod[79:16]; op <= OP_MY; end
              OP_MY:  begin mym <= prod[79:16]; op <= OP_MX2; end
              OP_MX2: begin sq <= prod; op <= OP_MY2; end
              OP_MY2: seg_sq <= seg_sq_next;
              default: ;
            endcase
          end
        end
        S_DIV_GO: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_done) begin
            t     <= {1'b0, quo};
            state <= S_MUL_GO;
          end
        end
        S_FIN: begin
          if (!last) begin
            running_min <= newmin;
            state       <= S_IDLE;
          end else if (out_load) begin
            best_sq       <= newmin;
            within_radius <= (newmin <= (64'(radius) << DIST_FRAC_BITS));
            running_min   <= '1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lon_factor <= LON_SCALE_RST;
      lat_factor <= LAT_SCALE_RST;
      radius     <= RADIUS_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_LON_SCALE: lon_factor <= pwdata;
        REG_LAT_SCALE: lat_factor <= pwdata;
        REG_RADIUS:    radius     <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_LON_SCALE: prdata = lon_factor;
      REG_LAT_SCALE: prdata = lat_factor;
      REG_RADIUS:    prdata = radius;
      default:       prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  ppmd_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .done  (mul_done),
    .prod  (prod)
  );

  ppmd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (quo)
  );

  `PPMD_ASSERT_NEVER(a_units_exclusive, mul_busy && div_busy)
  `PPMD_ASSERT_IMP(a_idle_units_free, in_ready, !mul_busy && !div_busy)
  `PPMD_ASSERT_NEXT(a_min_rearmed, out_load, running_min == '1)

endmodule

// ===== src/ppmd_mul.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on ppmd_pkg.
module ppmd_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ppmd_pkg::MUL_W-1:0]    a,
  input  logic [ppmd_pkg::MUL_W-1:0]    b,
  output logic                          busy,
  output logic                          done,
  output logic [ppmd_pkg::PROD_W-1:0]   prod
);
  import ppmd_pkg::*;

  logic [MUL_W-1:0] acand;
  logic [MUL_W-1:0] hi;
  logic [MUL_W-1:0] lo;
  logic [CNT_W-1:0] cnt;
  logic [MUL_W:0]   sum;

  always_comb begin
    sum = {1'b0, hi} + (lo[0] ? {1'b0, acand} : {(MUL_W+1){1'b0}});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        hi    <= '0;
        lo    <= b;
        acand <= a;
        cnt   <= CNT_W'(MUL_W);
        busy  <= 1'b1;
      end else if (busy) begin
        hi  <= sum[MUL_W:1];
        lo  <= {sum[0], lo[MUL_W-1:1]};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign prod = {hi, lo};

endmodule

// ===== src/ppmd_div.sv =====
// Restoring divider for the projection parameter, one quotient bit per cycle.
// Depends on ppmd_pkg.
module ppmd_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ppmd_pkg::REM_W-1:0]    num,
  input  logic [ppmd_pkg::REM_W-1:0]    den,
  output logic                          busy,
  output logic                          done,
  output logic [ppmd_pkg::T_FRAC-1:0]   quo
);
  import ppmd_pkg::*;

  logic [REM_W-1:0]  rem;
  logic [REM_W-1:0]  dsr;
  logic [REM_W-1:0]  r2;
  logic              ge;
  logic [QCNT_W-1:0] cnt;

  // remainder stays below the divisor, so the top bit is free for the shift
  always_comb begin
    r2 = {rem[REM_W-2:0], 1'b0};
    ge = (r2 >= dsr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= num;
        dsr  <= den;
        quo  <= '0;
        cnt  <= QCNT_W'(T_FRAC);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? (r2 - dsr) : r2;
        quo <= {quo[T_FRAC-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == QCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
